// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMP(name, clk, rstn, pre, post) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define ASSERT_NXT(name, clk, rstn, pre, post) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/pgfb_pkg.sv =====
// ----------------------------------------------------------------------------
// pgfb_pkg
// Types and codes for the page-mode framebuffer shape drawer
// ----------------------------------------------------------------------------
`default_nettype none

package pgfb_pkg;

	// command modes
	localparam logic [3:0] MODE_CLR   = 4'd0;
	localparam logic [3:0] MODE_PIX   = 4'd1;
	localparam logic [3:0] MODE_HLINE = 4'd2;
	localparam logic [3:0] MODE_VLINE = 4'd3;
	localparam logic [3:0] MODE_OUTL  = 4'd4;
	localparam logic [3:0] MODE_FILL  = 4'd5;
	localparam logic [3:0] MODE_BAR   = 4'd6;
	localparam logic [3:0] MODE_RBAR  = 4'd7;
	localparam logic [3:0] MODE_READ  = 4'd8;

	// rows per page byte
	localparam int PAGE_ROWS = 8;

	// segment slots of a bar: top, bottom, left and right sides then the fill
	localparam logic [2:0] SEG_TOP  = 3'd0;
	localparam logic [2:0] SEG_BOT  = 3'd1;
	localparam logic [2:0] SEG_LEFT = 3'd2;
	localparam logic [2:0] SEG_RGT  = 3'd3;
	localparam logic [2:0] SEG_FILL = 3'd4;

	typedef struct packed {
		logic [3:0] mode;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] span_w;
		logic [7:0] span_h;
		logic [7:0] level;
		logic [7:0] level_max;
		logic       ink;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       done_res;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DRAW,
		ST_READ,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/page_framebuffer_shape_drawer.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_shape_drawer
// Monochrome page-mode framebuffer with shape drawing and byte read-back
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel: a drawing or read request enters when cmd_valid is high and
//   cmd_stall is low. cmd_stall is high while a request is being worked on.
//   res channel: one result per request (read_byte, done_res) is held in an
//   output register until res_valid is seen with res_stall low. The next
//   request is taken while that result still waits; a request only finishes
//   once the output register has room.
//   Drawing: each shape is split into up to five rectangles (edges and fill).
//   The pixel walker issues one read-modify-write per cycle through the
//   single frame memory for each on-screen pixel that it walks; off-screen
//   pixels and empty rectangles are stepped over without a memory access.
//   Progress bars first run a multiply and a bit-serial divide for the
//   fill width.
//   Reset: after arst_n the memory is swept to zero, one byte per cycle,
//   over all SCREEN_WIDTH * ceil(SCREEN_HEIGHT/8) bytes (1024 by default),
//   with cmd_stall held high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module page_framebuffer_shape_drawer #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_stall,
	input  wire pgfb_pkg::cmd_t  cmd,
	output logic                 res_valid,
	input  wire logic            res_stall,
	output pgfb_pkg::res_t       res
);

	localparam int PAGE_COUNT = (SCREEN_HEIGHT + pgfb_pkg::PAGE_ROWS - 1) / pgfb_pkg::PAGE_ROWS;
	localparam int DEPTH      = SCREEN_WIDTH * PAGE_COUNT;
	localparam int AW         = $clog2(DEPTH);
	localparam logic [AW-1:0] DEPTH_M1 = AW'(DEPTH - 1);
	localparam logic [AW-1:0] WIDTH_A  = AW'(SCREEN_WIDTH);
	localparam logic [8:0]    WIDTH_9  = 9'(SCREEN_WIDTH);
	localparam logic [8:0]    HEIGHT_9 = 9'(SCREEN_HEIGHT);

	pgfb_pkg::state_t state_q, state_d;
	pgfb_pkg::cmd_t   cmd_q;

	logic [AW-1:0] clr_q;
	logic [2:0]    seg_q;
	logic [7:0]    i_q, j_q;
	logic [7:0]    mx_q;
	logic [15:0]   quo_q;
	logic [7:0]    rem_q;
	logic [3:0]    div_cnt_q;

	// frame memory and its ports
	logic [7:0]    mem [DEPTH];
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [7:0]    mem_wd;
	logic [7:0]    rdata_s1;

	// pixel pipeline
	logic          pix_vld_s1;
	logic [AW-1:0] pix_addr_s1;
	logic [7:0]    pix_mask_s1;
	logic          pix_on_s1;
	logic          wr_vld_q;
	logic [AW-1:0] wr_addr_q;
	logic [7:0]    wr_data_q;
	logic [7:0]    pix_base, pix_new;

	logic          res_vld_q;
	pgfb_pkg::res_t res_q;

	// derived command values
	logic [7:0] w2, h2, fw;
	logic       is_bar;
	logic [7:0] mx_eff, lvl_eff;
	logic       accept;

	assign accept  = cmd_valid && !cmd_stall;
	assign w2      = (cmd_q.span_w >= 8'd2) ? cmd_q.span_w - 8'd2 : 8'd0;
	assign h2      = (cmd_q.span_h >= 8'd2) ? cmd_q.span_h - 8'd2 : 8'd0;
	assign fw      = quo_q[7:0];
	assign is_bar  = (cmd_q.mode == pgfb_pkg::MODE_BAR) || (cmd_q.mode == pgfb_pkg::MODE_RBAR);
	assign mx_eff  = (cmd_q.level_max == 8'd0) ? 8'd1 : cmd_q.level_max;
	assign lvl_eff = (cmd_q.level > mx_eff) ? mx_eff : cmd_q.level;

	// segment of the current shape: origin and size
	logic [7:0] sx, sy, sw, sh;
	logic [2:0] seg_last;
	logic       pix_on;

	always_comb begin
		sx       = cmd_q.pos_x;
		sy       = cmd_q.pos_y;
		sw       = 8'd1;
		sh       = 8'd1;
		seg_last = pgfb_pkg::SEG_TOP;
		pix_on   = 1'b1;
		case (cmd_q.mode) inside
			pgfb_pkg::MODE_CLR: pix_on = 1'b0;
			pgfb_pkg::MODE_PIX: pix_on = cmd_q.ink;
			pgfb_pkg::MODE_HLINE: sw = cmd_q.span_w;
			pgfb_pkg::MODE_VLINE: sh = cmd_q.span_h;
			pgfb_pkg::MODE_FILL: begin
				sw = cmd_q.span_w;
				sh = cmd_q.span_h;
			end
			pgfb_pkg::MODE_OUTL, pgfb_pkg::MODE_BAR: begin
				seg_last = (cmd_q.mode == pgfb_pkg::MODE_OUTL) ? pgfb_pkg::SEG_RGT
				                                               : pgfb_pkg::SEG_FILL;
				case (seg_q)
					pgfb_pkg::SEG_TOP: sw = cmd_q.span_w;
					pgfb_pkg::SEG_BOT: begin
						sy = cmd_q.pos_y + cmd_q.span_h - 8'd1;
						sw = cmd_q.span_w;
					end
					pgfb_pkg::SEG_LEFT: sh = cmd_q.span_h;
					pgfb_pkg::SEG_RGT: begin
						sx = cmd_q.pos_x + cmd_q.span_w - 8'd1;
						sh = cmd_q.span_h;
					end
					default: begin
						sx = cmd_q.pos_x + 8'd1;
						sy = cmd_q.pos_y + 8'd1;
						sw = fw;
						sh = h2;
					end
				endcase
			end
			pgfb_pkg::MODE_RBAR: begin
				seg_last = pgfb_pkg::SEG_FILL;
				case (seg_q)
					pgfb_pkg::SEG_TOP: begin
						sx = cmd_q.pos_x + 8'd1;
						sw = w2;
					end
					pgfb_pkg::SEG_BOT: begin
						sx = cmd_q.pos_x + 8'd1;
						sy = cmd_q.pos_y + cmd_q.span_h - 8'd1;
						sw = w2;
					end
					pgfb_pkg::SEG_LEFT: begin
						sy = cmd_q.pos_y + 8'd1;
						sh = h2;
					end
					pgfb_pkg::SEG_RGT: begin
						sx = cmd_q.pos_x + cmd_q.span_w - 8'd1;
						sy = cmd_q.pos_y + 8'd1;
						sh = h2;
					end
					default: begin
						sx = cmd_q.pos_x + 8'd1;
						sy = cmd_q.pos_y + 8'd1;
						sw = fw;
						sh = h2;
					end
				endcase
			end
			default: ;
		endcase
	end

	// pixel under the walker and its place in memory
	logic [7:0]    px, py;
	logic          seg_empty, seg_end, row_end;
	logic          pix_onscr, rd_onscr;
	logic [AW-1:0] pix_addr, rd_addr;
	logic [7:0]    pix_mask;

	assign px        = sx + i_q;
	assign py        = sy + j_q;
	assign seg_empty = (sw == 8'd0) || (sh == 8'd0);
	assign row_end   = (i_q == sw - 8'd1);
	assign seg_end   = seg_empty || (row_end && (j_q == sh - 8'd1));
	assign pix_onscr = ({1'b0, px} < WIDTH_9) && ({1'b0, py} < HEIGHT_9);
	assign pix_addr  = AW'(py[7:3]) * WIDTH_A + AW'(px);
	assign pix_mask  = 8'd1 << py[2:0];
	assign rd_onscr  = ({1'b0, cmd_q.pos_x} < WIDTH_9) && ({1'b0, cmd_q.pos_y} < HEIGHT_9);
	assign rd_addr   = AW'(cmd_q.pos_y[7:3]) * WIDTH_A + AW'(cmd_q.pos_x);

	// divider step: shift in one dividend bit and trial-subtract
	logic [8:0] div_trial;
	logic       div_neg;
	assign div_trial = {rem_q, quo_q[15]} - {1'b0, mx_q};
	assign div_neg   = div_trial[8] && !rem_q[7];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pgfb_pkg::ST_CLEAR: if (clr_q == DEPTH_M1) state_d = pgfb_pkg::ST_IDLE;
			pgfb_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.mode) inside
						pgfb_pkg::MODE_BAR, pgfb_pkg::MODE_RBAR: state_d = pgfb_pkg::ST_MUL;
						pgfb_pkg::MODE_READ: state_d = pgfb_pkg::ST_READ;
						[pgfb_pkg::MODE_CLR:pgfb_pkg::MODE_FILL]: state_d = pgfb_pkg::ST_DRAW;
						default: state_d = pgfb_pkg::ST_DONE;
					endcase
				end
			end
			pgfb_pkg::ST_MUL: state_d = pgfb_pkg::ST_DIV;
			pgfb_pkg::ST_DIV: if (div_cnt_q == 4'hF) state_d = pgfb_pkg::ST_DRAW;
			pgfb_pkg::ST_DRAW: if (seg_end && (seg_q == seg_last)) state_d = pgfb_pkg::ST_DONE;
			pgfb_pkg::ST_READ: state_d = pgfb_pkg::ST_DONE;
			pgfb_pkg::ST_DONE: if (!res_vld_q || !res_stall) state_d = pgfb_pkg::ST_IDLE;
			default: state_d = pgfb_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	logic pix_issue, rd_issue, res_load;
	always_comb begin
		cmd_stall = 1'b1;
		pix_issue = 1'b0;
		rd_issue  = 1'b0;
		res_load  = 1'b0;
		unique case (state_q)
			pgfb_pkg::ST_IDLE: cmd_stall = 1'b0;
			pgfb_pkg::ST_DRAW: pix_issue = !seg_empty && pix_onscr;
			pgfb_pkg::ST_READ: rd_issue = rd_onscr;
			pgfb_pkg::ST_DONE: res_load = !res_vld_q || !res_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pgfb_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == pgfb_pkg::ST_CLEAR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// request capture, walker and divider
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			seg_q <= pgfb_pkg::SEG_TOP;
			i_q   <= 8'd0;
			j_q   <= 8'd0;
		end
		if (state_q == pgfb_pkg::ST_MUL) begin
			quo_q     <= 16'(lvl_eff) * 16'(w2);
			mx_q      <= mx_eff;
			rem_q     <= 8'd0;
			div_cnt_q <= 4'd0;
		end
		if (state_q == pgfb_pkg::ST_DIV) begin
			quo_q     <= {quo_q[14:0], !div_neg};
			rem_q     <= div_neg ? {rem_q[6:0], quo_q[15]} : div_trial[7:0];
			div_cnt_q <= div_cnt_q + 4'd1;
		end
		if (state_q == pgfb_pkg::ST_DRAW) begin
			if (seg_end) begin
				seg_q <= seg_q + 3'd1;
				i_q   <= 8'd0;
				j_q   <= 8'd0;
			end else if (row_end) begin
				i_q <= 8'd0;
				j_q <= j_q + 8'd1;
			end else begin
				i_q <= i_q + 8'd1;
			end
		end
	end

	// pixel pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_vld_s1 <= 1'b0;
			wr_vld_q   <= 1'b0;
		end else begin
			pix_vld_s1 <= pix_issue;
			wr_vld_q   <= pix_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pix_addr_s1 <= pix_addr;
		pix_mask_s1 <= pix_mask;
		pix_on_s1   <= pix_on;
		wr_addr_q   <= pix_addr_s1;
		wr_data_q   <= pix_new;
	end

	// modify: forward the byte written last cycle if it is the same one
	assign pix_base = (wr_vld_q && (wr_addr_q == pix_addr_s1)) ? wr_data_q : rdata_s1;
	assign pix_new  = pix_on_s1 ? (pix_base | pix_mask_s1) : (pix_base & ~pix_mask_s1);

	// memory port selection
	assign mem_we = (state_q == pgfb_pkg::ST_CLEAR) || pix_vld_s1;
	assign mem_wa = (state_q == pgfb_pkg::ST_CLEAR) ? clr_q : pix_addr_s1;
	assign mem_wd = (state_q == pgfb_pkg::ST_CLEAR) ? 8'd0 : pix_new;
	assign mem_re = pix_issue || rd_issue;
	assign mem_ra = rd_issue ? rd_addr : pix_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_s1 <= mem[mem_ra];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (res_load) begin
			res_vld_q <= 1'b1;
		end else if (!res_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.read_byte <= ((cmd_q.mode == pgfb_pkg::MODE_READ) && rd_onscr) ? rdata_s1 : 8'd0;
			res_q.done_res  <= 1'b1;
		end
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

	// checks
	`ASSERT_IMP(a_clear_no_pixel, clk, arst_n,
		state_q == pgfb_pkg::ST_CLEAR, !pix_vld_s1 && !mem_re)
	`ASSERT_IMP(a_pix_in_range, clk, arst_n, pix_vld_s1, pix_addr_s1 <= DEPTH_M1)
	`ASSERT_IMP(a_pix_mask_onehot, clk, arst_n, pix_vld_s1, $onehot(pix_mask_s1))
	`ASSERT_IMP(a_bar_width, clk, arst_n, (state_q == pgfb_pkg::ST_DRAW) && is_bar,
		(quo_q[15:8] == 8'd0) && (fw <= w2))
	`ASSERT_NXT(a_done_to_idle, clk, arst_n, res_load, state_q == pgfb_pkg::ST_IDLE && res_vld_q)

endmodule

`default_nettype wire

// ===== sim/page_framebuffer_shape_drawer_test.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_shape_drawer_test
// Self-checking bench for the page-mode framebuffer shape drawer: requests
// are queued by an initial block and driven with random gaps, each accepted
// request is painted into a local copy of the framebuffer, and every result
// is checked against the prediction in order.
// ----------------------------------------------------------------------------

module page_framebuffer_shape_drawer_test;

	localparam int FB_W     = 128;
	localparam int FB_H     = 64;
	localparam int FB_DEPTH = FB_W * ((FB_H + pgfb_pkg::PAGE_ROWS - 1) / pgfb_pkg::PAGE_ROWS);
	localparam int RAND_CMDS = 1050;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	pgfb_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	pgfb_pkg::res_t res;

	// local framebuffer copy and bookkeeping
	bit [7:0]          frame_model [FB_DEPTH];
	pgfb_pkg::cmd_t    pending_cmds [$];
	pgfb_pkg::res_t    res_due [$];
	int                cmd_total    = 0;
	int                cmds_taken   = 0;
	int                res_seen     = 0;
	int                faults       = 0;
	longint unsigned   cycle_budget = 0;
	longint unsigned   cycle_limit  = 0;
	longint unsigned   cycles       = 0;

	page_framebuffer_shape_drawer #(
		.SCREEN_WIDTH (FB_W),
		.SCREEN_HEIGHT(FB_H)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------- painter

	// one pixel, sums wrap at 256, off-screen pixels dropped
	function automatic void plot(input int unsigned x, input int unsigned y, input bit on);
		int unsigned px;
		int unsigned py;
		px = x & 32'hFF;
		py = y & 32'hFF;
		if (px < FB_W && py < FB_H)
			frame_model[(py / pgfb_pkg::PAGE_ROWS) * FB_W + px][py % pgfb_pkg::PAGE_ROWS] = on;
	endfunction

	function automatic void draw_hline(input int unsigned x, input int unsigned y,
			input int unsigned w);
		for (int unsigned i = 0; i < w; i++)
			plot(x + i, y, 1'b1);
	endfunction

	function automatic void draw_vline(input int unsigned x, input int unsigned y,
			input int unsigned h);
		for (int unsigned i = 0; i < h; i++)
			plot(x, y + i, 1'b1);
	endfunction

	function automatic void fill_box(input int unsigned x, input int unsigned y,
			input int unsigned w, input int unsigned h);
		for (int unsigned i = 0; i < h; i++)
			draw_hline(x, y + i, w);
	endfunction

	// zero height puts the lower edge on row y-1
	function automatic void draw_box(input int unsigned x, input int unsigned y,
			input int unsigned w, input int unsigned h);
		draw_hline(x, y, w);
		draw_hline(x, y + h + 255, w);
		draw_vline(x, y, h);
		draw_vline(x + w + 255, y, h);
	endfunction

	function automatic int unsigned less_two(input int unsigned v);
		return (v >= 2) ? v - 2 : 0;
	endfunction

	// progress fill: zero full scale counts as one, level clamped
	function automatic void bar_fill(input int unsigned x, input int unsigned y,
			input int unsigned w, input int unsigned h,
			input int unsigned lv, input int unsigned mx);
		int unsigned fw;
		if (mx == 0)
			mx = 1;
		if (lv > mx)
			lv = mx;
		fw = (lv * less_two(w)) / mx;
		if (fw > 0)
			fill_box(x + 1, y + 1, fw, less_two(h));
	endfunction

	// apply one request to the framebuffer copy and return its result
	function automatic pgfb_pkg::res_t paint_cmd(input pgfb_pkg::cmd_t c);
		int unsigned x;
		int unsigned y;
		int unsigned w;
		int unsigned h;
		int unsigned lv;
		int unsigned mx;
		pgfb_pkg::res_t r;
		x  = 32'(c.pos_x);
		y  = 32'(c.pos_y);
		w  = 32'(c.span_w);
		h  = 32'(c.span_h);
		lv = 32'(c.level);
		mx = 32'(c.level_max);
		r.read_byte = 8'h00;
		r.done_res  = 1'b1;
		case (c.mode)
			pgfb_pkg::MODE_CLR:   plot(x, y, 1'b0);
			pgfb_pkg::MODE_PIX:   plot(x, y, c.ink);
			pgfb_pkg::MODE_HLINE: draw_hline(x, y, w);
			pgfb_pkg::MODE_VLINE: draw_vline(x, y, h);
			pgfb_pkg::MODE_OUTL:  draw_box(x, y, w, h);
			pgfb_pkg::MODE_FILL:  fill_box(x, y, w, h);
			pgfb_pkg::MODE_BAR: begin
				draw_box(x, y, w, h);
				bar_fill(x, y, w, h, lv, mx);
			end
			pgfb_pkg::MODE_RBAR: begin
				draw_hline(x + 1, y, less_two(w));
				draw_hline(x + 1, y + h + 255, less_two(w));
				draw_vline(x, y + 1, less_two(h));
				draw_vline(x + w + 255, y + 1, less_two(h));
				bar_fill(x, y, w, h, lv, mx);
			end
			pgfb_pkg::MODE_READ: begin
				if (x < FB_W && y < FB_H)
					r.read_byte = frame_model[(y / pgfb_pkg::PAGE_ROWS) * FB_W + x];
			end
			default: ;
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic pgfb_pkg::cmd_t shape_cmd(input logic [3:0] mode, input logic [7:0] x,
			input logic [7:0] y, input logic [7:0] w, input logic [7:0] h,
			input logic [7:0] lv, input logic [7:0] mx, input logic ink);
		pgfb_pkg::cmd_t c;
		c.mode      = mode;
		c.pos_x     = x;
		c.pos_y     = y;
		c.span_w    = w;
		c.span_h    = h;
		c.level     = lv;
		c.level_max = mx;
		c.ink       = ink;
		return c;
	endfunction

	// queue a request and add its worst-case cycle cost to the budget
	task automatic queue_cmd(input pgfb_pkg::cmd_t c);
		pending_cmds.push_back(c);
		cmd_total++;
		cycle_budget += (longint'(c.span_w) + 2) * (longint'(c.span_h) + 2) + 200;
	endtask

	// mostly small spans, a few medium, rarely up to the full byte
	function automatic logic [7:0] pick_span(input bit allow_long);
		int r;
		r = $urandom_range(99);
		if (r < 90)
			return 8'($urandom_range(8));
		else if (r < 98 || !allow_long)
			return 8'($urandom_range(40));
		else
			return 8'($urandom_range(255));
	endfunction

	// idle percentage per phase; the two sides swap, then both run flat out
	function automatic int idle_pct(input bit rx_side);
		int phase;
		if (cmd_total == 0)
			return 0;
		phase = cmds_taken * 3 / cmd_total;
		case (phase)
			0:       return rx_side ? 80 : 31;
			1:       return rx_side ? 31 : 80;
			default: return 0;
		endcase
	endfunction

	initial begin
		pgfb_pkg::cmd_t c;
		int   r;

		// directed: corners, off-screen pixels and reads
		queue_cmd(shape_cmd(pgfb_pkg::MODE_PIX,   0,   0,  0, 0,   0,   0, 1'b1));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_PIX, 127,  63,  0, 0,   0,   0, 1'b1));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_PIX, 128,   5,  0, 0,   0,   0, 1'b1));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_PIX, 255, 255,  0, 0,   0,   0, 1'b1));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_READ,  0,   0,  0, 0,   0,   0, 1'b0));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_READ,127,  60,  0, 0,   0,   0, 1'b0));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_READ,128,   0,  0, 0,   0,   0, 1'b0));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_READ,  5, 255,  0, 0,   0,   0, 1'b0));
		// clear ignores ink, pixel mode with ink low clears
		queue_cmd(shape_cmd(pgfb_pkg::MODE_CLR,   0,   0,  0, 0,   0,   0, 1'b1));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_PIX, 127,  63,  0, 0,   0,   0, 1'b0));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_READ,127,  56,  0, 0,   0,   0, 1'b0));
		// lines with wrap and full length
		queue_cmd(shape_cmd(pgfb_pkg::MODE_HLINE, 250, 3, 20,   0, 0, 0, 1'b0));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_HLINE,   0, 10, 255, 0, 0, 0, 1'b1));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_VLINE, 127, 0,  0, 255, 0, 0, 1'b0));
		// outlines with zero height and zero width
		queue_cmd(shape_cmd(pgfb_pkg::MODE_OUTL, 10, 20, 5, 0, 0, 0, 1'b0));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_OUTL, 30, 30, 0, 5, 0, 0, 1'b0));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_FILL, 60, 40, 255, 3, 0, 0, 1'b0));
		// bars: clamped level, zero full scale, tiny spans, wide wrap
		queue_cmd(shape_cmd(pgfb_pkg::MODE_BAR,   2,  2,  20, 6, 200, 100, 1'b0));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_BAR,  40, 12,   9, 5,   5,   0, 1'b0));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_BAR,  70, 50,   1, 1, 255, 255, 1'b0));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_BAR, 200, 45, 255, 8, 255, 255, 1'b1));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_RBAR,  90,  2, 10, 5, 3, 7, 1'b0));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_RBAR, 100, 20,  1, 1, 9, 9, 1'b0));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_RBAR, 110, 30,  2, 2, 1, 1, 1'b0));
		// unused modes
		queue_cmd(shape_cmd(4'd9,  1, 1, 3, 3, 1, 1, 1'b1));
		queue_cmd(shape_cmd(4'd15, 2, 2, 4, 4, 2, 2, 1'b0));
		queue_cmd(shape_cmd(pgfb_pkg::MODE_READ, 90, 2, 0, 0, 0, 0, 1'b0));

		// random requests, weighted toward reads and small shapes
		for (int i = 0; i < RAND_CMDS; i++) begin
			r = $urandom_range(99);
			if (r < 25)
				c.mode = pgfb_pkg::MODE_READ;
			else if (r < 35)
				c.mode = pgfb_pkg::MODE_PIX;
			else if (r < 45)
				c.mode = pgfb_pkg::MODE_CLR;
			else if (r < 53)
				c.mode = pgfb_pkg::MODE_HLINE;
			else if (r < 61)
				c.mode = pgfb_pkg::MODE_VLINE;
			else if (r < 70)
				c.mode = pgfb_pkg::MODE_OUTL;
			else if (r < 79)
				c.mode = pgfb_pkg::MODE_FILL;
			else if (r < 89)
				c.mode = pgfb_pkg::MODE_BAR;
			else if (r < 97)
				c.mode = pgfb_pkg::MODE_RBAR;
			else
				c.mode = 4'($urandom_range(15, 9));
			c.pos_x = ($urandom_range(99) < 75) ? 8'($urandom_range(127))
					: 8'($urandom_range(255));
			c.pos_y = ($urandom_range(99) < 75) ? 8'($urandom_range(63))
					: 8'($urandom_range(255));
			c.span_w = pick_span(1'b1);
			if (c.mode >= pgfb_pkg::MODE_OUTL && c.mode <= pgfb_pkg::MODE_RBAR
					&& c.span_w > 8'd40)
				c.span_h = 8'($urandom_range(6));
			else
				c.span_h = pick_span(1'b1);
			c.level     = 8'($urandom_range(255));
			c.level_max = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255));
			c.ink       = 1'($urandom_range(1));
			queue_cmd(c);
		end

		// generous: several times the slowest run, plus the clearing sweep
		cycle_limit = 4 * cycle_budget + 8 * FB_DEPTH + 10000;

		// reset once
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// drain
		while (!(cmds_taken == cmd_total && res_due.size() == 0))
			@(posedge clk);
		repeat (64) @(posedge clk);

		if (faults == 0 && res_due.size() == 0)
			$display("** page_framebuffer_shape_drawer: PASSED **");
		else
			$display("** page_framebuffer_shape_drawer: FAILED **");
		$finish;
	end

	// ---------------------------------------------------------------- driver

	// request side: predict on accept, then offer the next request or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				res_due.push_back(paint_cmd(cmd));
				cmds_taken++;
			end
			if (!cmd_valid || !cmd_stall) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
					cmd       <= pending_cmds.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic log_fault(input string msg);
		faults++;
		if (faults <= 10)
			$display("%s", msg);
	endtask

	// result side: compare against the oldest prediction, stall at random
	always @(posedge clk) begin
		pgfb_pkg::res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (res_due.size() == 0) begin
					log_fault($sformatf("result %0d: unexpected, read_byte %02h done_res %b",
							res_seen, res.read_byte, res.done_res));
				end else begin
					want = res_due.pop_front();
					if (res.read_byte !== want.read_byte)
						log_fault($sformatf("result %0d: read_byte expected %02h, got %02h",
								res_seen, want.read_byte, res.read_byte));
					if (res.done_res !== want.done_res)
						log_fault($sformatf("result %0d: done_res expected %b, got %b",
								res_seen, want.done_res, res.done_res));
				end
				res_seen++;
			end
			res_stall <= ($urandom_range(99) < idle_pct(1'b1));
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > cycle_limit) begin
			$display("** page_framebuffer_shape_drawer: FAILED **");
			$finish;
		end
	end

endmodule
